### design/bfha_pkg.sv
// ----------------------------------------------------------------------------
// bfha_pkg
// Shared types and codes for the best-fit heap allocator.
// ----------------------------------------------------------------------------
package bfha_pkg;

  localparam int unsigned CMD_W  = 1;
  localparam int unsigned REQ_W  = 16;
  localparam int unsigned OFF_W  = 12;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_MERGE,
    S_DONE
  } state_t;

  // operation broadcast from the sequencer to every cell
  typedef enum logic [2:0] {
    OP_NONE,
    OP_SHRINK,    // shrink cell at target by need
    OP_INSERT,    // cells after target shift right, target+1 takes new segment
    OP_MARKFREE,  // target becomes free
    OP_REMOVE,    // cells after target shift left over target
    OP_GROW       // target size grows by delta
  } op_t;

endpackage

### design/bfha_if.sv
// ----------------------------------------------------------------------------
// bfha_in_if / bfha_out_if
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
interface bfha_in_if;
  logic        valid;
  logic        ready;
  logic [0:0]  command;
  logic [15:0] request_size;
  logic [11:0] data_offset;
  modport source (output valid, command, request_size, data_offset, input ready);
  modport sink   (input valid, command, request_size, data_offset, output ready);
endinterface

interface bfha_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] result_offset;
  logic [1:0]  status;
  modport source (output valid, result_offset, status, input ready);
  modport sink   (input valid, result_offset, status, output ready);
endinterface

### design/bfha_cell.sv
// ----------------------------------------------------------------------------
// bfha_cell
// One segment slot: holds offset, size and used mark, evaluates fit and
// address match, and shifts with its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module bfha_cell #(
  parameter int unsigned IDX_W = 8,
  parameter int unsigned AW    = 13,
  parameter int unsigned INDEX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rst_valid,
  input  logic [AW-1:0]    rst_size,
  input  bfha_pkg::op_t    op,
  input  logic [IDX_W-1:0] target,
  input  logic [AW-1:0]    arg_off,
  input  logic [AW-1:0]    arg_size,
  input  logic [AW:0]      need,
  input  logic [AW-1:0]    match_off,
  // left neighbor (index-1) and right neighbor (index+1)
  input  logic             lv,
  input  logic [AW-1:0]    loff,
  input  logic [AW-1:0]    lsize,
  input  logic             lused,
  input  logic             rv,
  input  logic [AW-1:0]    roff,
  input  logic [AW-1:0]    rsize,
  input  logic             rused,
  output logic             valid,
  output logic [AW-1:0]    off,
  output logic [AW-1:0]    size,
  output logic             used,
  output logic             fits,
  output logic             hit
);
  import bfha_pkg::*;

  localparam logic [IDX_W-1:0] ME = IDX_W'(INDEX);

  logic          valid_r, valid_nxt, used_r, used_nxt;
  logic [AW-1:0] off_r, off_nxt, size_r, size_nxt;

  // local compares
  assign fits = valid_r && !used_r && ({1'b0, size_r} >= need);
  assign hit  = valid_r && used_r && (off_r == match_off);

  // slot update
  always_comb begin
    valid_nxt = valid_r;
    off_nxt   = off_r;
    size_nxt  = size_r;
    used_nxt  = used_r;
    case (op)
      OP_SHRINK: if (ME == target) size_nxt = size_r - need[AW-1:0];
      OP_INSERT: begin
        if (ME == target + 1'b1) begin
          valid_nxt = 1'b1;
          off_nxt   = arg_off;
          size_nxt  = arg_size;
          used_nxt  = 1'b1;
        end else if (ME > target + 1'b1 && INDEX > 0) begin
          valid_nxt = lv;
          off_nxt   = loff;
          size_nxt  = lsize;
          used_nxt  = lused;
        end
      end
      OP_MARKFREE: if (ME == target) used_nxt = 1'b0;
      OP_REMOVE: if (ME >= target) begin
        valid_nxt = rv;
        off_nxt   = roff;
        size_nxt  = rsize;
        used_nxt  = rused;
      end
      OP_GROW: if (ME == target) size_nxt = size_r + arg_size;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= rst_valid;
      used_r  <= 1'b0;
      off_r   <= '0;
      size_r  <= rst_size;
    end else begin
      valid_r <= valid_nxt;
      used_r  <= used_nxt;
      off_r   <= off_nxt;
      size_r  <= size_nxt;
    end
  end

  assign valid = valid_r;
  assign off   = off_r;
  assign size  = size_r;
  assign used  = used_r;
endmodule

### design/best_fit_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// best_fit_heap_allocator_top
// Best-fit allocator with coalescing over a row of segment cells.
// ----------------------------------------------------------------------------
// Each request word is handled alone and its latency grows with the length of
// its scan. Every cell compares its segment against the request in
// parallel, and a scan then visits one cell a cycle through a shared
// comparator: an allocate looks at every live segment for the smallest fitting
// one, a free stops at the used segment whose header matches. An allocate then
// shrinks the chosen segment, then shifts the row right and inserts the new one,
// and a free takes four or five merge steps (mark free, grow over a free right
// neighbor, remove it, grow a free left neighbor, remove the freed slot). The
// S_DONE state then raises the result valid flag; a word rejected up front goes
// there straight from the scan. The result sits in an output register and the
// next word is taken once it has been delivered.
module best_fit_heap_allocator_top #(
  parameter int unsigned ARENA_BYTES  = 4096,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned MAX_SEGMENTS = 256
) (
  input  logic   clk,
  input  logic   rst_n,
  bfha_in_if.sink    in_ch,
  bfha_out_if.source out_ch
);
  import bfha_pkg::*;

  localparam int unsigned AW    = $clog2(ARENA_BYTES + 1);
  localparam int unsigned IDX_W = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [AW-1:0] HDR = AW'(HEADER_BYTES);

  // row of cells
  logic          c_v[MAX_SEGMENTS], c_u[MAX_SEGMENTS], c_fit[MAX_SEGMENTS];
  logic          c_hit[MAX_SEGMENTS];
  logic [AW-1:0] c_off[MAX_SEGMENTS], c_sz[MAX_SEGMENTS];

  op_t              op;
  logic [IDX_W-1:0] op_tgt;
  logic [IDX_W-1:0] tgt_r, tgt_nxt;
  logic [AW-1:0]    arg_off, arg_size;
  logic [AW:0]      need_r, need_nxt;
  logic [AW-1:0]    moff_r, moff_nxt;

  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    localparam int unsigned LI = (i == 0) ? 0 : i - 1;
    localparam int unsigned RI = (i == MAX_SEGMENTS - 1) ? i : i + 1;
    bfha_cell #(.IDX_W(IDX_W), .AW(AW), .INDEX(i)) u_cell (
      .clk, .rst_n,
      .rst_valid (i == 0),
      .rst_size  ((i == 0) ? AW'(ARENA_BYTES - HEADER_BYTES) : '0),
      .op, .target(op_tgt), .arg_off, .arg_size, .need(need_r),
      .match_off (moff_r),
      .lv(c_v[LI]), .loff(c_off[LI]), .lsize(c_sz[LI]), .lused(c_u[LI]),
      .rv((i == MAX_SEGMENTS - 1) ? 1'b0 : c_v[RI]),
      .roff(c_off[RI]), .rsize(c_sz[RI]), .rused(c_u[RI]),
      .valid(c_v[i]), .off(c_off[i]), .size(c_sz[i]), .used(c_u[i]),
      .fits(c_fit[i]), .hit(c_hit[i])
    );
  end

  state_t           st_r, st_nxt;
  logic             cmd_r, cmd_nxt;
  logic [REQ_W-1:0] req_r, req_nxt;
  logic [IDX_W-1:0] scan_r, scan_nxt;
  logic             found_r, found_nxt;
  logic [AW-1:0]    best_sz_r, best_sz_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       mstep_r, mstep_nxt;
  logic             ovf_r, ovf_nxt;
  logic [OFF_W-1:0] res_off_r, res_off_nxt;
  status_t          stat_r, stat_nxt;
  logic             ov_r, ov_nxt;

  // scanned cell
  logic          sc_fit, sc_hit, sc_last;
  logic [AW-1:0] sc_sz;
  assign sc_fit  = c_fit[scan_r];
  assign sc_hit  = c_hit[scan_r];
  assign sc_sz   = c_sz[scan_r];
  assign sc_last = ({1'b0, scan_r} == CNT_W'(cnt_r - 1'b1));

  logic [IDX_W-1:0] tp1, tm1;
  logic             has_r;
  assign tp1 = tgt_r + 1'b1;
  assign tm1 = tgt_r - 1'b1;
  // target has a live right neighbor
  assign has_r = (CNT_W'(tgt_r) + CNT_W'(1)) < cnt_r;

  assign in_ch.ready = (st_r == S_IDLE) && !ov_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (in_ch.valid && in_ch.ready) st_nxt = S_SCAN;
      S_SCAN: begin
        if (ovf_r) st_nxt = S_DONE;
        else if (cmd_r == CMD_FREE && sc_hit) st_nxt = S_MERGE;
        else if (sc_last) st_nxt = (cmd_r == CMD_ALLOC && (found_r || sc_fit) &&
                                    cnt_r < CNT_W'(MAX_SEGMENTS)) ? S_SHIFT : S_DONE;
      end
      S_SHIFT: if (mstep_r == 2'd1) st_nxt = S_DONE;
      S_MERGE: if (mstep_r == 2'd3) st_nxt = S_DONE;
      S_DONE:  st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // datapath and cell commands
  always_comb begin
    cmd_nxt = cmd_r; req_nxt = req_r; scan_nxt = scan_r; found_nxt = found_r;
    best_sz_nxt = best_sz_r; tgt_nxt = tgt_r; need_nxt = need_r;
    moff_nxt = moff_r; cnt_nxt = cnt_r; mstep_nxt = mstep_r; ovf_nxt = ovf_r;
    res_off_nxt = res_off_r; stat_nxt = stat_r; ov_nxt = ov_r;
    op = OP_NONE; op_tgt = tgt_r; arg_off = '0; arg_size = '0;
    if (ov_r && out_ch.ready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: if (in_ch.valid && in_ch.ready) begin
        cmd_nxt = in_ch.command; req_nxt = in_ch.request_size;
        scan_nxt = '0; found_nxt = 1'b0; mstep_nxt = '0;
        need_nxt = (AW+1)'({1'b0, in_ch.request_size} + 17'(HEADER_BYTES));
        moff_nxt = AW'(in_ch.data_offset) - HDR;
        // request plus header larger than the arena, or free offset below the header size
        ovf_nxt = (in_ch.command == CMD_FREE) ?
                  (in_ch.data_offset < OFF_W'(HEADER_BYTES)) :
                  ({1'b0, in_ch.request_size} + 17'(HEADER_BYTES) >
                   17'(ARENA_BYTES));
      end
      S_SCAN: begin
        if (cmd_r == CMD_ALLOC && sc_fit && (!found_r || sc_sz <= best_sz_r)) begin
          found_nxt = 1'b1; best_sz_nxt = sc_sz; tgt_nxt = scan_r;
        end
        if (cmd_r == CMD_FREE && sc_hit) tgt_nxt = scan_r;
        scan_nxt = scan_r + 1'b1;
        if (ovf_r || (cmd_r == CMD_ALLOC && sc_last) ||
            (cmd_r == CMD_FREE && sc_last && !sc_hit)) begin
          stat_nxt = (cmd_r == CMD_FREE) ? ST_BADFREE : ST_NOFIT;
          res_off_nxt = '0;
        end
      end
      S_SHIFT: begin
        mstep_nxt = mstep_r + 1'b1;
        if (mstep_r == 2'd0) op = OP_SHRINK;
        else begin
          op = OP_INSERT;
          arg_off  = c_off[tgt_r] + HDR + c_sz[tgt_r];
          arg_size = AW'(req_r);
          cnt_nxt  = cnt_r + 1'b1;
          stat_nxt = ST_OK;
          res_off_nxt = OFF_W'(arg_off + HDR);
        end
      end
      S_MERGE: begin
        mstep_nxt = mstep_r + 1'b1;
        stat_nxt = ST_OK; res_off_nxt = '0;
        case (mstep_r)
          2'd0: op = OP_MARKFREE;
          2'd1: if (has_r && !c_u[tp1]) begin
            op = OP_GROW; arg_size = c_sz[tp1] + HDR;
          end
          default: ;
        endcase
        // remove the absorbed right neighbor, then fold into a free left one
        if (mstep_r == 2'd2) begin
          if (!ovf_r && has_r && !c_u[tp1]) begin
            op = OP_REMOVE; op_tgt = tp1; cnt_nxt = cnt_r - 1'b1;
            mstep_nxt = 2'd2;
            // mark consumed so the next pass checks the left side
            ovf_nxt = 1'b1;
          end else if (tgt_r != '0 && !c_u[tm1]) begin
            op = OP_GROW; op_tgt = tm1; arg_size = c_sz[tgt_r] + HDR;
            tgt_nxt = tm1; mstep_nxt = 2'd3; found_nxt = 1'b1;
          end else mstep_nxt = 2'd3;
        end
        if (mstep_r == 2'd3 && found_r) begin
          op = OP_REMOVE; op_tgt = tp1; cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_DONE: ov_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; cnt_r <= CNT_W'(1);
      found_r <= 1'b0; mstep_r <= '0; ovf_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; cnt_r <= cnt_nxt;
      found_r <= found_nxt; mstep_r <= mstep_nxt; ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; req_r <= req_nxt; scan_r <= scan_nxt;
    best_sz_r <= best_sz_nxt; tgt_r <= tgt_nxt; need_r <= need_nxt;
    moff_r <= moff_nxt; res_off_r <= res_off_nxt; stat_r <= stat_nxt;
  end

  assign out_ch.valid         = ov_r;
  assign out_ch.result_offset = res_off_r;
  assign out_ch.status        = stat_r;
endmodule

### design/bfha_checker.sv
// ----------------------------------------------------------------------------
// bfha_props
// Port-level checks on the allocator's request and result channels.
// ----------------------------------------------------------------------------
module bfha_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_result_offset,
  input logic [1:0]  out_status
);
  import bfha_pkg::*;

  // result payload holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_result_offset) && $stable(out_status))
    else $error("result word changed while stalled");

  // no new request while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken with result pending");

  // failed results carry zero offset
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result_offset == '0)
    else $error("nonzero offset on failure");

  // status codes stay in range
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("bad status code");
endmodule

bind best_fit_heap_allocator_top bfha_props u_bfha_checker (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_result_offset(out_ch.result_offset), .out_status(out_ch.status)
);
